// ===== hw/rtl/positional_array_list_defines.svh =====
// assertion macros used by the checker
`ifndef POSITIONAL_ARRAY_LIST_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define PAL_ASSERT(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("pal check failed");

// implication checked on the same edge
`define PAL_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pal check failed");

// implication checked on the following edge
`define PAL_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pal check failed");

`endif

// ===== hw/rtl/pal_pkg.sv =====
package pal_pkg;

    localparam int CAPACITY = 16;

    localparam int REQ_W   = 3;
    localparam int POS_W   = 5;
    localparam int DATA_W  = 8;
    localparam int STAT_W  = 2;
    localparam int ENTRY_W = 5;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [REQ_W-1:0] REQ_APPEND  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_READ    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_REPLACE = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    typedef enum logic [1:0] {
        CS_IDLE = 2'b01,
        CS_HOLD = 2'b10
    } ctrl_state_t;

    typedef struct packed {
        logic exec;
    } pal_cmd_t;

endpackage

// ===== hw/rtl/pal_dp.sv =====
module pal_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pal_pkg::pal_cmd_t             cmd,
    input  logic [pal_pkg::REQ_W-1:0]     req_type,
    input  logic [pal_pkg::POS_W-1:0]     position,
    input  logic [pal_pkg::DATA_W-1:0]    data_in,
    output logic [pal_pkg::DATA_W-1:0]    data_out,
    output logic [pal_pkg::STAT_W-1:0]    status,
    output logic [pal_pkg::ENTRY_W-1:0]   entry_count,
    output logic                          is_empty,
    output logic                          is_full
);
    import pal_pkg::*;

    logic [DATA_W-1:0]  slots_reg  [CAPACITY];
    logic [DATA_W-1:0]  slots_next [CAPACITY];
    logic [CNT_W-1:0]   used_reg;
    logic [CNT_W-1:0]   used_next;

    logic [DATA_W-1:0]  data_out_reg;
    logic [STAT_W-1:0]  status_reg;
    logic [ENTRY_W-1:0] entry_count_reg;
    logic               is_empty_reg;
    logic               is_full_reg;

    logic [CMP_W-1:0]   pos_c;
    logic [CMP_W-1:0]   used_c;
    logic               list_full;
    logic [DATA_W-1:0]  rd_data;
    logic [DATA_W-1:0]  got;
    logic [STAT_W-1:0]  status_c;
    logic               op_app;
    logic               op_ins;
    logic               op_del;
    logic               op_rep;

    assign pos_c     = CMP_W'(position);
    assign used_c    = CMP_W'(used_reg);
    assign list_full = (used_reg >= CNT_W'(CAPACITY));

    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (CMP_W'(i) == pos_c)
            begin
                rd_data = slots_reg[i];
            end
        end
    end

    // request decode and checks
    always_comb
    begin
        status_c = ST_OK;
        got      = '0;
        op_app   = 1'b0;
        op_ins   = 1'b0;
        op_del   = 1'b0;
        op_rep   = 1'b0;
        case (req_type)
            REQ_APPEND:
            begin
                if (list_full)
                    status_c = ST_FULL;
                else
                    op_app = 1'b1;
            end
            REQ_INSERT:
            begin
                if (list_full)
                    status_c = ST_FULL;
                else if (pos_c > used_c)
                    status_c = ST_RANGE;
                else
                    op_ins = 1'b1;
            end
            REQ_DELETE, REQ_READ, REQ_REPLACE:
            begin
                if (used_reg == '0)
                    status_c = ST_EMPTY;
                else if (pos_c >= used_c)
                    status_c = ST_RANGE;
                else if (req_type == REQ_DELETE)
                begin
                    got    = rd_data;
                    op_del = 1'b1;
                end
                else if (req_type == REQ_READ)
                    got = rd_data;
                else
                    op_rep = 1'b1;
            end
            default:
            begin
                status_c = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        used_next = used_reg;
        if (op_app || op_ins)
            used_next = used_reg + CNT_W'(1);
        else if (op_del)
            used_next = used_reg - CNT_W'(1);
    end

    // each slot takes its own value, its lower or its upper neighbor, or the new byte
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_slot
        logic [DATA_W-1:0] lower;
        logic [DATA_W-1:0] upper;
        logic [CMP_W-1:0]  idx;
        logic [CMP_W-1:0]  idx_up;

        if (g == 0)
        begin : g_first
            assign lower = slots_reg[0];
        end
        else
        begin : g_mid
            assign lower = slots_reg[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign upper = slots_reg[g];
        end
        else
        begin : g_low
            assign upper = slots_reg[g+1];
        end

        assign idx    = CMP_W'(g);
        assign idx_up = CMP_W'(g + 1);

        always_comb
        begin
            slots_next[g] = slots_reg[g];
            if (op_app && idx == used_c)
                slots_next[g] = data_in;
            else if (op_rep && idx == pos_c)
                slots_next[g] = data_in;
            else if (op_ins && idx == pos_c)
                slots_next[g] = data_in;
            else if (op_ins && idx > pos_c && idx <= used_c)
                slots_next[g] = lower;
            else if (op_del && idx >= pos_c && idx_up < used_c)
                slots_next[g] = upper;
        end

        always_ff @(posedge clk)
        begin
            if (cmd.exec)
                slots_reg[g] <= slots_next[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            used_reg <= '0;
        else if (cmd.exec)
            used_reg <= used_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            data_out_reg    <= got;
            status_reg      <= status_c;
            entry_count_reg <= ENTRY_W'(used_next);
            is_empty_reg    <= (used_next == '0);
            is_full_reg     <= (used_next >= CNT_W'(CAPACITY));
        end
    end

    assign data_out    = data_out_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;
    assign is_empty    = is_empty_reg;
    assign is_full     = is_full_reg;

endmodule

// ===== hw/rtl/pal_ctrl.sv =====
module pal_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output pal_pkg::pal_cmd_t cmd
);
    import pal_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    assign in_stall  = (state_reg == CS_HOLD) && out_stall;
    assign out_valid = (state_reg == CS_HOLD);
    assign cmd.exec  = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (cmd.exec)
                    state_next = CS_HOLD;
            end
            CS_HOLD:
            begin
                if (cmd.exec)
                    state_next = CS_HOLD;
                else if (!out_stall)
                    state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CS_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hw/rtl/positional_array_list.sv =====
// Positional byte list of pal_pkg::CAPACITY entries, packed from position 0.
// Each input transaction is one request (append, insert, delete, read or
// replace) and returns exactly one result transaction in the cycle after it is
// accepted, with the byte read or removed, a status code and the entry count
// and empty/full flags after the request. A new request is accepted every
// cycle while the result side takes results; the rate is one transaction per
// clock, set by the row of slot registers; those affected all shift by one
// position in the same cycle on insert and delete. A rejected request leaves
// the list as it was. Request codes 5 to 7 are taken as no-ops with status ok.
module positional_array_list (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pal_pkg::REQ_W-1:0]     req_type,
    input  logic [pal_pkg::POS_W-1:0]     position,
    input  logic [pal_pkg::DATA_W-1:0]    data_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pal_pkg::DATA_W-1:0]    data_out,
    output logic [pal_pkg::STAT_W-1:0]    status,
    output logic [pal_pkg::ENTRY_W-1:0]   entry_count,
    output logic                          is_empty,
    output logic                          is_full
);
    import pal_pkg::*;

    pal_cmd_t cmd;

    pal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    pal_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req_type    (req_type),
        .position    (position),
        .data_in     (data_in),
        .data_out    (data_out),
        .status      (status),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .is_full     (is_full)
    );

endmodule

// ===== hw/rtl/pal_checker.sv =====
`include "positional_array_list_defines.svh"

module pal_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [pal_pkg::DATA_W-1:0]    data_out,
    input logic [pal_pkg::STAT_W-1:0]    status,
    input logic [pal_pkg::ENTRY_W-1:0]   entry_count,
    input logic                          is_empty,
    input logic                          is_full
);
    import pal_pkg::*;

    `PAL_ASSERT_IMP(a_empty_count, out_valid && is_empty, entry_count == '0)
    `PAL_ASSERT_IMP(a_not_both, out_valid && is_full, !is_empty)
    `PAL_ASSERT_IMP(a_flag_no_data, out_valid && status != ST_OK, data_out == '0)
    `PAL_ASSERT_NEXT(a_accept_result, in_valid && !in_stall, out_valid)
    `PAL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

endmodule

bind positional_array_list pal_checker u_pal_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .data_out    (data_out),
    .status      (status),
    .entry_count (entry_count),
    .is_empty    (is_empty),
    .is_full     (is_full)
);

// ===== sim/tb.sv =====
module tb;
    import pal_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0]  data;
        logic [STAT_W-1:0]  status;
        logic [ENTRY_W-1:0] count;
        logic               empty;
        logic               full;
    } list_result_t;

    class list_scoreboard;
        logic [DATA_W-1:0] slots [CAPACITY];
        int                count;
        list_result_t      expected_q [$];
        int                errors;
        int                requests;
        int                checked;
        int                status_seen [4];

        function new();
            count = 0;
            errors = 0;
            requests = 0;
            checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(logic [REQ_W-1:0] kind, logic [POS_W-1:0] pos,
                                   logic [DATA_W-1:0] value);
            list_result_t r;
            r.data = '0;
            r.status = ST_OK;
            case (kind)
                REQ_APPEND:
                    if (count >= CAPACITY) r.status = ST_FULL;
                    else
                    begin
                        slots[count] = value;
                        count++;
                    end
                REQ_INSERT:
                    if (count >= CAPACITY) r.status = ST_FULL;
                    else if (pos > count) r.status = ST_RANGE;
                    else
                    begin
                        for (int i = count; i > pos; i--) slots[i] = slots[i-1];
                        slots[pos] = value;
                        count++;
                    end
                REQ_DELETE, REQ_READ, REQ_REPLACE:
                    if (count == 0) r.status = ST_EMPTY;
                    else if (pos >= count) r.status = ST_RANGE;
                    else if (kind == REQ_DELETE)
                    begin
                        r.data = slots[pos];
                        for (int i = pos; i + 1 < count; i++) slots[i] = slots[i+1];
                        count--;
                    end
                    else if (kind == REQ_READ) r.data = slots[pos];
                    else slots[pos] = value;
                default: ;
            endcase
            r.count = count[ENTRY_W-1:0];
            r.empty = (count == 0);
            r.full = (count >= CAPACITY);
            status_seen[r.status]++;
            requests++;
            expected_q.push_back(r);
        endfunction

        function void check_result(list_result_t got);
            list_result_t want;
            checked++;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result transaction: data %0h status %0d count %0d",
                             got.data, got.status, got.count);
                return;
            end
            want = expected_q.pop_front();
            if (got.data !== want.data || got.status !== want.status ||
                got.count !== want.count || got.empty !== want.empty ||
                got.full !== want.full)
            begin
                errors++;
                if (errors <= 10)
                    $display("result %0d: expected data %0h status %0d count %0d empty %0b ",
                             checked, want.data, want.status, want.count, want.empty,
                             "full %0b, got data %0h status %0d count %0d empty %0b full %0b",
                             want.full, got.data, got.status, got.count, got.empty, got.full);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [REQ_W-1:0]   req_type = '0;
    logic [POS_W-1:0]   position = '0;
    logic [DATA_W-1:0]  data_in = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [DATA_W-1:0]  data_out;
    logic [STAT_W-1:0]  status;
    logic [ENTRY_W-1:0] entry_count;
    logic               is_empty;
    logic               is_full;

    int             idle_pct = 0;
    int             stall_pct = 0;
    bit             growing = 1'b1;
    list_scoreboard tracker = new();

    positional_array_list DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .position    (position),
        .data_in     (data_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_out    (data_out),
        .status      (status),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .is_full     (is_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result({data_out, status, entry_count, is_empty, is_full});
        out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    // called at a rising edge; leaves in_valid high so back-to-back requests need no gap
    task send_request(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                      input logic [DATA_W-1:0] value);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        req_type <= kind;
        position <= pos;
        data_in <= value;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        tracker.note_request(kind, pos, value);
    endtask

    task send_random_request();
        logic [REQ_W-1:0]  kind;
        logic [POS_W-1:0]  pos;
        int                r;
        if ($urandom_range(24) == 0) growing = !growing;
        r = $urandom_range(99);
        if ($urandom_range(99) < 10)
        begin
            kind = REQ_W'($urandom_range(7));
            pos = POS_W'($urandom_range(31));
        end
        else
        begin
            if (growing)
                kind = (r < 35) ? REQ_APPEND : (r < 65) ? REQ_INSERT : (r < 75) ? REQ_DELETE :
                       (r < 88) ? REQ_READ : REQ_REPLACE;
            else
                kind = (r < 10) ? REQ_APPEND : (r < 20) ? REQ_INSERT : (r < 55) ? REQ_DELETE :
                       (r < 78) ? REQ_READ : REQ_REPLACE;
            if (kind == REQ_INSERT) pos = POS_W'($urandom_range(tracker.count));
            else pos = (tracker.count > 0) ? POS_W'($urandom_range(tracker.count - 1)) : '0;
        end
        send_request(kind, pos, DATA_W'($urandom_range(255)));
    endtask

    task wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
    endtask

    task run_phase(input int items, input int idle, input int stall);
        idle_pct = idle;
        stall_pct = stall;
        repeat (items) send_random_request();
        wait_for_results();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, out-of-range and no-op code cases
        send_request(REQ_DELETE, 5'd0, 8'h11);
        send_request(REQ_READ, 5'd0, 8'h22);
        send_request(REQ_REPLACE, 5'd0, 8'h33);
        send_request(REQ_INSERT, 5'd1, 8'h44);
        send_request(REQ_INSERT, 5'd0, 8'hFF);
        send_request(REQ_APPEND, 5'd0, 8'h00);
        send_request(REQ_INSERT, 5'd2, 8'hA5);
        send_request(REQ_INSERT, 5'd0, 8'h5A);
        send_request(REQ_READ, 5'd31, 8'h00);
        send_request(REQ_DELETE, 5'd4, 8'h00);
        send_request(REQ_REPLACE, 5'd1, 8'hC3);
        send_request(REQ_READ, 5'd1, 8'h00);
        send_request(REQ_READ, 5'd3, 8'h00);
        send_request(3'd5, 5'd16, 8'hFF);
        send_request(3'd6, 5'd0, 8'h00);
        send_request(3'd7, 5'd31, 8'h80);
        send_request(REQ_DELETE, 5'd3, 8'h00);
        send_request(REQ_DELETE, 5'd0, 8'h00);
        send_request(REQ_DELETE, 5'd1, 8'h00);
        send_request(REQ_DELETE, 5'd0, 8'h00);
        send_request(REQ_APPEND, 5'd16, 8'h7F);
        wait_for_results();

        run_phase(490, 0, 0);
        run_phase(490, 82, 0);
        run_phase(490, 0, 82);
        run_phase(490, 31, 31);

        stall_pct = 0;
        repeat (10) @(posedge clk);
        $display("%0d requests, %0d results checked", tracker.requests, tracker.checked);
        $display("status ok %0d, full %0d, empty %0d, out of range %0d",
                 tracker.status_seen[ST_OK], tracker.status_seen[ST_FULL],
                 tracker.status_seen[ST_EMPTY], tracker.status_seen[ST_RANGE]);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("positional_array_list: match");
        else
            $display("positional_array_list: mismatch");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("positional_array_list: mismatch");
        $finish;
    end
endmodule
